// ===== hdl/rbs_pkg.sv =====
// Shared constants for the ray / box slab intersection block.
// No dependencies; compile first.
package rbs_pkg;

	// Default coordinate format: signed Q16.16
	localparam int COORD_WIDTH_DEF = 32;
	localparam int FRAC_BITS_DEF   = 16;

endpackage

// ===== hdl/rbs_if.sv =====
// Valid/ready channels for the ray beat and the result beat.
// Depends on rbs_pkg for default widths.
interface rbs_ray_if #(parameter int W = rbs_pkg::COORD_WIDTH_DEF);
	logic                valid;
	logic                ready;
	logic signed [W-1:0] origin_x;
	logic signed [W-1:0] origin_y;
	logic signed [W-1:0] origin_z;
	logic signed [W-1:0] dir_x;
	logic signed [W-1:0] dir_y;
	logic signed [W-1:0] dir_z;
	logic signed [W-1:0] box_min_x;
	logic signed [W-1:0] box_min_y;
	logic signed [W-1:0] box_min_z;
	logic signed [W-1:0] box_max_x;
	logic signed [W-1:0] box_max_y;
	logic signed [W-1:0] box_max_z;

	modport source (output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
		box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z, input ready);
	modport sink (input valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
		box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z, output ready);
endinterface

interface rbs_hit_if #(parameter int W = rbs_pkg::COORD_WIDTH_DEF);
	logic                valid;
	logic                ready;
	logic                hit;
	logic signed [W-1:0] hit_x;
	logic signed [W-1:0] hit_y;
	logic signed [W-1:0] hit_z;

	modport source (output valid, hit, hit_x, hit_y, hit_z, input ready);
	modport sink (input valid, hit, hit_x, hit_y, hit_z, output ready);
endinterface

// ===== hdl/ray_box_slab_intersection.sv =====
// Ray / axis-aligned box slab test: top level with the slab and entry-point stages.
// Depends on rbs_pkg, rbs_if, rbs_recip and rbs_mul_sat.
//
// One ray beat in, one result beat out, in order. The block is a single
// fully pipelined datapath that takes a new beat in every clock cycle while
// the result side keeps taking beats; coordinates default to Q16.16. The
// reciprocal divider resolves one quotient bit per stage over 2*FRAC_BITS + 1
// stages, preceded by a magnitude stage and followed by a saturation stage.
// Then come the face-difference stage, a three-stage multiplier for the six
// slab parameters, the interval narrowing stage, a three-stage multiplier for
// direction * entry parameter, and the output register. All stages share one
// enable: when a result beat sits unaccepted the whole pipeline holds, and
// ready on the ray side drops in the same cycle. A zero direction component
// takes the largest positive reciprocal. A ray whose origin lies inside the
// box reports a miss, since its entry parameter is negative; misses carry
// zero coordinates.
module ray_box_slab_intersection #(
	parameter int COORD_WIDTH = rbs_pkg::COORD_WIDTH_DEF,
	parameter int FRAC_BITS   = rbs_pkg::FRAC_BITS_DEF
) (
	input logic       clk,
	input logic       arst_n,
	rbs_ray_if.sink   ray,
	rbs_hit_if.source res
);
	localparam int W = COORD_WIDTH;
	localparam int F = FRAC_BITS;
	localparam logic signed [W-1:0] CMAX = {1'b0, {(W-1){1'b1}}};
	localparam logic signed [W-1:0] CMIN = {1'b1, {(W-1){1'b0}}};

	logic en;

	// reciprocal stage; the rest of the ray rides along as side payload,
	// packed origin xyz, dir xyz, min xyz, max xyz from the bottom up
	logic signed [W-1:0] dir_in [3];
	logic [12*W-1:0]     rside_in;
	logic                rcp_vld;
	logic signed [W-1:0] rcp [3];
	logic [12*W-1:0]     rside_out;
	logic signed [W-1:0] r_o  [3];
	logic signed [W-1:0] r_lo [3];
	logic signed [W-1:0] r_hi [3];

	// face differences
	logic signed [W:0]   dn_s1 [3];
	logic signed [W:0]   df_s1 [3];
	logic signed [W-1:0] r_s1  [3];
	logic [6*W-1:0]      od_s1;
	logic                vld_s1;

	// slab parameters
	logic signed [W:0]   ta   [6];
	logic signed [W-1:0] tb   [6];
	logic                t_vld;
	logic signed [W-1:0] t_p  [6];
	logic [6*W-1:0]      t_side;

	// interval narrowing
	logic signed [W-1:0] tmin_d;
	logic signed [W-1:0] tmax_d;
	logic                hit_d;
	logic signed [W-1:0] tmin_s2;
	logic                hit_s2;
	logic [6*W-1:0]      od_s2;
	logic                vld_s2;

	// entry point
	logic signed [W:0]   ea   [3];
	logic signed [W-1:0] eb   [3];
	logic                e_vld;
	logic signed [W-1:0] e_p  [3];
	logic [3*W:0]        e_side;
	logic signed [W-1:0] coord_d [3];

	logic                vld_q;
	logic                hit_q;
	logic signed [W-1:0] hit_x_q;
	logic signed [W-1:0] hit_y_q;
	logic signed [W-1:0] hit_z_q;

	// advance everything unless a finished beat is still waiting
	assign en        = !vld_q || res.ready;
	assign ray.ready = en;

	assign dir_in[0] = ray.dir_x;
	assign dir_in[1] = ray.dir_y;
	assign dir_in[2] = ray.dir_z;
	assign rside_in  = {ray.box_max_z, ray.box_max_y, ray.box_max_x,
		ray.box_min_z, ray.box_min_y, ray.box_min_x,
		ray.dir_z, ray.dir_y, ray.dir_x,
		ray.origin_z, ray.origin_y, ray.origin_x};

	rbs_recip #(
		.W      (W),
		.F      (F),
		.LANES  (3),
		.SIDE_W (12*W)
	) u_recip (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (ray.valid),
		.den      (dir_in),
		.in_side  (rside_in),
		.out_vld  (rcp_vld),
		.rcp      (rcp),
		.out_side (rside_out)
	);

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			r_o[k]  = $signed(rside_out[k*W +: W]);
			r_lo[k] = $signed(rside_out[(6+k)*W +: W]);
			r_hi[k] = $signed(rside_out[(9+k)*W +: W]);
		end
	end

	// pick near/far face by the reciprocal's sign, take exact differences
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				if (!rcp[k][W-1]) begin
					dn_s1[k] <= {r_lo[k][W-1], r_lo[k]} - {r_o[k][W-1], r_o[k]};
					df_s1[k] <= {r_hi[k][W-1], r_hi[k]} - {r_o[k][W-1], r_o[k]};
				end else begin
					dn_s1[k] <= {r_hi[k][W-1], r_hi[k]} - {r_o[k][W-1], r_o[k]};
					df_s1[k] <= {r_lo[k][W-1], r_lo[k]} - {r_o[k][W-1], r_o[k]};
				end
				r_s1[k] <= rcp[k];
			end
			od_s1 <= rside_out[6*W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_q  <= 1'b0;
		end else if (en) begin
			vld_s1 <= rcp_vld;
			vld_s2 <= t_vld;
			vld_q  <= e_vld;
		end
	end

	// lanes 0..2 are near parameters, 3..5 far parameters
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			ta[k]     = dn_s1[k];
			ta[k + 3] = df_s1[k];
			tb[k]     = r_s1[k];
			tb[k + 3] = r_s1[k];
		end
	end

	rbs_mul_sat #(
		.W      (W),
		.F      (F),
		.AW     (W + 1),
		.LANES  (6),
		.SIDE_W (6*W)
	) u_slab_mul (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (vld_s1),
		.a        (ta),
		.b        (tb),
		.in_side  (od_s1),
		.out_vld  (t_vld),
		.p        (t_p),
		.out_side (t_side)
	);

	// narrow x, then y, then z; an empty interval or a negative bound misses
	always_comb begin
		tmin_d = t_p[0];
		tmax_d = t_p[3];
		hit_d  = 1'b1;
		for (int k = 1; k < 3; k++) begin
			if (tmin_d > t_p[k + 3] || t_p[k] > tmax_d) begin
				hit_d = 1'b0;
			end
			if (t_p[k] > tmin_d) begin
				tmin_d = t_p[k];
			end
			if (t_p[k + 3] < tmax_d) begin
				tmax_d = t_p[k + 3];
			end
		end
		if (tmin_d[W-1] || tmax_d[W-1]) begin
			hit_d = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tmin_s2 <= tmin_d;
			hit_s2  <= hit_d;
			od_s2   <= t_side;
		end
	end

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			ea[k] = {od_s2[(3+k)*W + W-1], od_s2[(3+k)*W +: W]};
			eb[k] = tmin_s2;
		end
	end

	rbs_mul_sat #(
		.W      (W),
		.F      (F),
		.AW     (W + 1),
		.LANES  (3),
		.SIDE_W (3*W + 1)
	) u_entry_mul (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (vld_s2),
		.a        (ea),
		.b        (eb),
		.in_side  ({hit_s2, od_s2[3*W-1:0]}),
		.out_vld  (e_vld),
		.p        (e_p),
		.out_side (e_side)
	);

	// origin plus scaled direction, saturated; zero on a miss
	always_comb begin
		logic signed [W:0] s;
		for (int k = 0; k < 3; k++) begin
			s = {e_side[k*W + W-1], e_side[k*W +: W]} + {e_p[k][W-1], e_p[k]};
			if (!e_side[3*W]) begin
				coord_d[k] = '0;
			end else if (s[W] != s[W-1]) begin
				coord_d[k] = s[W] ? CMIN : CMAX;
			end else begin
				coord_d[k] = s[W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hit_q   <= e_side[3*W];
			hit_x_q <= coord_d[0];
			hit_y_q <= coord_d[1];
			hit_z_q <= coord_d[2];
		end
	end

	assign res.valid = vld_q;
	assign res.hit   = hit_q;
	assign res.hit_x = hit_x_q;
	assign res.hit_y = hit_y_q;
	assign res.hit_z = hit_z_q;

	// a miss leaves the output with zero coordinates
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q && !hit_q |-> hit_x_q == '0 && hit_y_q == '0 && hit_z_q == '0)
		else $error("miss beat with non-zero coordinates");

	// a hit never carries a negative entry parameter into the entry stage
	a_hit_tmin: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s2 && hit_s2 |-> !tmin_s2[W-1])
		else $error("hit with negative entry parameter");

	// a stall holds the narrowing stage in place
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(vld_s2) && $stable(tmin_s2) && $stable(hit_s2))
		else $error("narrowing stage moved during a stall");

endmodule

// ===== hdl/rbs_recip.sv =====
// Pipelined reciprocal 2^(2F)/d, one quotient bit per stage, saturating.
// Depends on rbs_pkg for default widths; stalls on the shared enable.
module rbs_recip #(
	parameter int W      = rbs_pkg::COORD_WIDTH_DEF,
	parameter int F      = rbs_pkg::FRAC_BITS_DEF,
	parameter int LANES  = 3,
	parameter int SIDE_W = 1
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                in_vld,
	input  logic signed [W-1:0] den [LANES],
	input  logic [SIDE_W-1:0]   in_side,
	output logic                out_vld,
	output logic signed [W-1:0] rcp [LANES],
	output logic [SIDE_W-1:0]   out_side
);
	localparam int QW = 2*F + 1;
	localparam int CW = (QW > W) ? QW : W;
	localparam logic signed [W-1:0] CMAX = {1'b0, {(W-1){1'b1}}};
	localparam logic signed [W-1:0] CMIN = {1'b1, {(W-1){1'b0}}};
	localparam logic [CW-1:0] CMAX_C = CW'({1'b0, {(W-1){1'b1}}});
	localparam logic [CW-1:0] HALF_C = CW'(1) << (W-1);

	// magnitude stage
	logic [W-1:0]       mag_s1 [LANES];
	logic [LANES-1:0]   neg_s1;
	logic [LANES-1:0]   zero_s1;
	logic               vld_s1;
	logic [SIDE_W-1:0]  side_s1;

	// division stages
	logic [W-1:0]       rem_sd  [QW][LANES];
	logic [QW-1:0]      quo_sd  [QW][LANES];
	logic [W-1:0]       dv_sd   [QW][LANES];
	logic [LANES-1:0]   neg_sd  [QW];
	logic [LANES-1:0]   zero_sd [QW];
	logic               vld_sd  [QW];
	logic [SIDE_W-1:0]  side_sd [QW];

	// saturation stage
	logic signed [W-1:0] rcp_s2 [LANES];
	logic                vld_s2;
	logic [SIDE_W-1:0]   side_s2;
	logic signed [W-1:0] rcp_d  [LANES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < LANES; l++) begin
				mag_s1[l]  <= den[l][W-1] ? W'(-den[l]) : W'(den[l]);
				neg_s1[l]  <= den[l][W-1];
				zero_s1[l] <= (den[l] == '0);
			end
			side_s1 <= in_side;
		end
	end

	for (genvar i = 0; i < QW; i++) begin : g_div
		logic [W-1:0]      rem_in  [LANES];
		logic [QW-1:0]     quo_in  [LANES];
		logic [W-1:0]      dv_in   [LANES];
		logic [W:0]        trial   [LANES];
		logic [LANES-1:0]  neg_in;
		logic [LANES-1:0]  zero_in;
		logic              vld_in;
		logic [SIDE_W-1:0] side_in;

		if (i == 0) begin : g_first
			always_comb begin
				for (int l = 0; l < LANES; l++) begin
					rem_in[l] = '0;
					quo_in[l] = '0;
					dv_in[l]  = mag_s1[l];
				end
			end
			assign neg_in  = neg_s1;
			assign zero_in = zero_s1;
			assign vld_in  = vld_s1;
			assign side_in = side_s1;
		end else begin : g_next
			always_comb begin
				for (int l = 0; l < LANES; l++) begin
					rem_in[l] = rem_sd[i-1][l];
					quo_in[l] = quo_sd[i-1][l];
					dv_in[l]  = dv_sd[i-1][l];
				end
			end
			assign neg_in  = neg_sd[i-1];
			assign zero_in = zero_sd[i-1];
			assign vld_in  = vld_sd[i-1];
			assign side_in = side_sd[i-1];
		end

		// the numerator is a single one bit at the top
		always_comb begin
			for (int l = 0; l < LANES; l++) begin
				trial[l] = {rem_in[l], 1'(i == 0)};
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_sd[i] <= 1'b0;
			end else if (en) begin
				vld_sd[i] <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				for (int l = 0; l < LANES; l++) begin
					if (trial[l] >= {1'b0, dv_in[l]}) begin
						rem_sd[i][l] <= W'(trial[l] - {1'b0, dv_in[l]});
						quo_sd[i][l] <= {quo_in[l][QW-2:0], 1'b1};
					end else begin
						rem_sd[i][l] <= trial[l][W-1:0];
						quo_sd[i][l] <= {quo_in[l][QW-2:0], 1'b0};
					end
					dv_sd[i][l] <= dv_in[l];
				end
				neg_sd[i]  <= neg_in;
				zero_sd[i] <= zero_in;
				side_sd[i] <= side_in;
			end
		end
	end

	always_comb begin
		logic [CW-1:0] qc;
		for (int l = 0; l < LANES; l++) begin
			qc = CW'(quo_sd[QW-1][l]);
			if (zero_sd[QW-1][l]) begin
				rcp_d[l] = CMAX;
			end else if (!neg_sd[QW-1][l]) begin
				rcp_d[l] = (qc > CMAX_C) ? CMAX : qc[W-1:0];
			end else begin
				rcp_d[l] = (qc > HALF_C) ? CMIN : W'(-qc);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s2 <= vld_sd[QW-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rcp_s2  <= rcp_d;
			side_s2 <= side_sd[QW-1];
		end
	end

	assign out_vld  = vld_s2;
	assign rcp      = rcp_s2;
	assign out_side = side_s2;

endmodule

// ===== hdl/rbs_mul_sat.sv =====
// Three-stage saturating fixed-point multiplier, (a*b) >> F on magnitudes.
// Depends on rbs_pkg for default widths; stalls on the shared enable.
module rbs_mul_sat #(
	parameter int W      = rbs_pkg::COORD_WIDTH_DEF,
	parameter int F      = rbs_pkg::FRAC_BITS_DEF,
	parameter int AW     = W + 1,
	parameter int LANES  = 1,
	parameter int SIDE_W = 1
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 in_vld,
	input  logic signed [AW-1:0] a [LANES],
	input  logic signed [W-1:0]  b [LANES],
	input  logic [SIDE_W-1:0]    in_side,
	output logic                 out_vld,
	output logic signed [W-1:0]  p [LANES],
	output logic [SIDE_W-1:0]    out_side
);
	localparam int HA = (AW + 1) / 2;
	localparam int LA = AW - HA;
	localparam int HB = (W + 1) / 2;
	localparam int LB = W - HB;
	localparam int PW = AW + W;
	localparam int MW = PW - F;
	localparam logic signed [W-1:0] CMAX = {1'b0, {(W-1){1'b1}}};
	localparam logic signed [W-1:0] CMIN = {1'b1, {(W-1){1'b0}}};
	localparam logic [MW-1:0] CMAX_M = MW'({1'b0, {(W-1){1'b1}}});
	localparam logic [MW-1:0] HALF_M = MW'(1) << (W-1);

	logic [AW-1:0]      ma_s1 [LANES];
	logic [W-1:0]       mb_s1 [LANES];
	logic [LANES-1:0]   neg_s1;
	logic               vld_s1;
	logic [SIDE_W-1:0]  side_s1;

	logic [HA+HB-1:0]   pll_s2 [LANES];
	logic [HA+LB-1:0]   plh_s2 [LANES];
	logic [LA+HB-1:0]   phl_s2 [LANES];
	logic [LA+LB-1:0]   phh_s2 [LANES];
	logic [LANES-1:0]   neg_s2;
	logic               vld_s2;
	logic [SIDE_W-1:0]  side_s2;

	logic signed [W-1:0] p_s3 [LANES];
	logic                vld_s3;
	logic [SIDE_W-1:0]   side_s3;
	logic signed [W-1:0] p_d  [LANES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	// magnitudes, then partial products
	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < LANES; l++) begin
				ma_s1[l]  <= a[l][AW-1] ? AW'(-a[l]) : AW'(a[l]);
				mb_s1[l]  <= b[l][W-1] ? W'(-b[l]) : W'(b[l]);
				neg_s1[l] <= a[l][AW-1] ^ b[l][W-1];
				pll_s2[l] <= ma_s1[l][HA-1:0] * mb_s1[l][HB-1:0];
				plh_s2[l] <= ma_s1[l][HA-1:0] * mb_s1[l][W-1:HB];
				phl_s2[l] <= ma_s1[l][AW-1:HA] * mb_s1[l][HB-1:0];
				phh_s2[l] <= ma_s1[l][AW-1:HA] * mb_s1[l][W-1:HB];
			end
			neg_s2  <= neg_s1;
			side_s1 <= in_side;
			side_s2 <= side_s1;
		end
	end

	// sum, drop fraction, saturate
	always_comb begin
		logic [PW-1:0] full;
		logic [MW-1:0] m;
		logic [MW-1:0] nm;
		for (int l = 0; l < LANES; l++) begin
			full = PW'(pll_s2[l]) + (PW'(plh_s2[l]) << HB) + (PW'(phl_s2[l]) << HA)
				+ (PW'(phh_s2[l]) << (HA + HB));
			m  = full[PW-1:F];
			nm = -m;
			if (neg_s2[l]) begin
				p_d[l] = (m > HALF_M) ? CMIN : nm[W-1:0];
			end else begin
				p_d[l] = (m > CMAX_M) ? CMAX : m[W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_s3    <= p_d;
			side_s3 <= side_s2;
		end
	end

	assign out_vld  = vld_s3;
	assign p        = p_s3;
	assign out_side = side_s3;

endmodule

// ===== tb/rbs_tb_if.sv =====
`timescale 1ns / 1ps
// Testbench-side note: the block's own channel interfaces live in hdl/rbs_if.sv.
// Holds the ray and expected-hit beat records for the testbench top; needs rbs_pkg.
package rbs_tb_pkg;
	localparam int W = rbs_pkg::COORD_WIDTH_DEF;
	localparam int F = rbs_pkg::FRAC_BITS_DEF;

	typedef struct packed {
		logic signed [W-1:0] ox, oy, oz, dx, dy, dz;
		logic signed [W-1:0] nx, ny, nz, xx, xy, xz;
	} ray_beat_t;

	typedef struct packed {
		logic                hit;
		logic signed [W-1:0] px, py, pz;
	} hit_beat_t;
endpackage

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for ray_box_slab_intersection: random and corner rays,
// predicted in fixed point here. Depends on rbs_pkg, rbs_if and rbs_tb_pkg.
module testbench;
	import rbs_tb_pkg::*;

	localparam int LATENCY = 2 * F + 12;
	localparam longint SMAX = (64'sd1 <<< (W - 1)) - 1;
	localparam longint SMIN = -SMAX - 1;
	localparam int CYCLE_LIMIT = 600000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	rbs_ray_if #(W) ray ();
	rbs_hit_if #(W) res ();

	ray_box_slab_intersection DUT (.clk(clk), .arst_n(arst_n), .ray(ray.sink), .res(res.source));

	// clock: 4 ns period, two delays
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	ray_beat_t pending_rays[$];
	hit_beat_t awaited_hits[$];
	int        send_idle_pct = 0;
	int        recv_stall_pct = 0;
	bit        hold_sender = 1'b0;
	bit        ray_taken = 1'b0;
	int        n_errors = 0;
	int        n_checked = 0;
	int        n_hits = 0;
	longint    cycles = 0;

	// saturate a wide value into the coordinate range
	function automatic longint clamp(input logic signed [127:0] v);
		if (v > SMAX) return SMAX;
		if (v < SMIN) return SMIN;
		return longint'(v);
	endfunction

	// (a*b) >> F on magnitudes, sign restored, saturated
	function automatic longint fx_mul(input longint a, input longint b);
		logic        [127:0] ma, mb, m;
		logic signed [127:0] s;
		ma = (a < 0) ? 128'(-a) : 128'(a);
		mb = (b < 0) ? 128'(-b) : 128'(b);
		m = (ma * mb) >> F;
		s = ((a < 0) != (b < 0)) ? -$signed(m) : $signed(m);
		return clamp(s);
	endfunction

	// reciprocal truncated toward zero; zero direction takes the top value
	function automatic longint fx_recip(input longint d);
		logic [127:0] q;
		if (d == 0) return SMAX;
		q = (128'd1 << (2 * F)) / ((d < 0) ? 128'(-d) : 128'(d));
		return clamp((d < 0) ? -$signed(q) : $signed(q));
	endfunction

	function automatic hit_beat_t predict_hit(input ray_beat_t r);
		longint o[3], d[3], lo[3], hi[3];
		longint tmin, tmax, tn, tf, rc;
		bit     meets;
		hit_beat_t h;
		o = '{r.ox, r.oy, r.oz};
		d = '{r.dx, r.dy, r.dz};
		lo = '{r.nx, r.ny, r.nz};
		hi = '{r.xx, r.xy, r.xz};
		meets = 1'b1;
		tmin = 0;
		tmax = 0;
		for (int i = 0; i < 3; i++) begin
			rc = fx_recip(d[i]);
			tn = fx_mul((rc >= 0 ? lo[i] : hi[i]) - o[i], rc);
			tf = fx_mul((rc >= 0 ? hi[i] : lo[i]) - o[i], rc);
			if (i == 0) begin
				tmin = tn;
				tmax = tf;
			end else if (meets) begin
				if (tmin > tf || tn > tmax) meets = 1'b0;
				else begin
					if (tn > tmin) tmin = tn;
					if (tf < tmax) tmax = tf;
				end
			end
		end
		if (tmax < 0 || tmin < 0) meets = 1'b0;
		h.hit = meets;
		h.px = meets ? W'(clamp(128'(o[0]) + fx_mul(d[0], tmin))) : '0;
		h.py = meets ? W'(clamp(128'(o[1]) + fx_mul(d[1], tmin))) : '0;
		h.pz = meets ? W'(clamp(128'(o[2]) + fx_mul(d[2], tmin))) : '0;
		return h;
	endfunction

	// random coordinate: mostly values within +/- span, sometimes zero or any bit pattern
	function automatic logic signed [W-1:0] rnd_coord(input int span);
		if ($urandom_range(99) < 8) return W'($urandom);
		if ($urandom_range(99) < 4) return W'(0);
		return W'($signed($urandom_range(2 * span)) - span);
	endfunction

	// well-formed ray: box ahead of the origin, aimed roughly at it
	function automatic ray_beat_t aimed_ray();
		ray_beat_t r;
		logic signed [W-1:0] c[3], h[3], o[3], dd[3];
		for (int i = 0; i < 3; i++) begin
			c[i] = rnd_coord(20 << F);
			h[i] = W'($urandom_range(8 << F, 1 << (F - 2)));
			o[i] = rnd_coord(40 << F);
			dd[i] = W'((c[i] - o[i]) >>> $urandom_range(4, 0));
			if ($urandom_range(9) == 0) dd[i] = rnd_coord(4 << F);
		end
		r = '{o[0], o[1], o[2], dd[0], dd[1], dd[2],
			c[0] - h[0], c[1] - h[1], c[2] - h[2], c[0] + h[0], c[1] + h[1], c[2] + h[2]};
		return r;
	endfunction

	function automatic ray_beat_t noise_ray();
		ray_beat_t r;
		r = '{rnd_coord(1 << 30), rnd_coord(1 << 30), rnd_coord(1 << 30),
			rnd_coord(1 << 30), rnd_coord(1 << 30), rnd_coord(1 << 30),
			rnd_coord(1 << 30), rnd_coord(1 << 30), rnd_coord(1 << 30),
			rnd_coord(1 << 30), rnd_coord(1 << 30), rnd_coord(1 << 30)};
		return r;
	endfunction

	// append a beat to the tail of the pending queue
	task automatic queue_ray(input ray_beat_t r);
		pending_rays.insert(pending_rays.size(), r);
	endtask

	// note whether the shown beat was taken at this rising edge
	always @(posedge clk) begin
		ray_taken <= ray.valid && ray.ready;
	end

	// driver: present the next beat at the falling edge, hold until taken
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ray.valid <= 1'b0;
			{ray.origin_x, ray.origin_y, ray.origin_z, ray.dir_x, ray.dir_y, ray.dir_z,
				ray.box_min_x, ray.box_min_y, ray.box_min_z,
				ray.box_max_x, ray.box_max_y, ray.box_max_z} <= '0;
		end else if (!ray.valid || ray_taken) begin
			// beat taken last edge (or none shown): choose idle or the next beat
			if (pending_rays.size() > 0 && !hold_sender &&
					$urandom_range(99) >= send_idle_pct) begin
				ray_beat_t r;
				r = pending_rays.pop_front();
				ray.valid <= 1'b1;
				{ray.origin_x, ray.origin_y, ray.origin_z, ray.dir_x, ray.dir_y, ray.dir_z,
					ray.box_min_x, ray.box_min_y, ray.box_min_z,
					ray.box_max_x, ray.box_max_y, ray.box_max_z} <= r;
			end else begin
				ray.valid <= 1'b0;
			end
		end
	end

	// result-side backpressure, also changed at the falling edge
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) res.ready <= 1'b0;
		else res.ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	task automatic report_mismatch(input string what, input longint got, input longint want);
		n_errors++;
		$display("MISMATCH %s: got %0d, expected %0d (beat %0d)", what, got, want, n_checked);
	endtask

	// monitor: at each rising edge predict accepted ray beats, check accepted result beats
	always @(posedge clk) begin
		if (arst_n) begin
			cycles <= cycles + 1;
			if (ray.valid && ray.ready)
				awaited_hits.insert(awaited_hits.size(),
					predict_hit({ray.origin_x, ray.origin_y, ray.origin_z,
					ray.dir_x, ray.dir_y, ray.dir_z, ray.box_min_x, ray.box_min_y, ray.box_min_z,
					ray.box_max_x, ray.box_max_y, ray.box_max_z}));
			if (res.valid && res.ready) begin
				if (awaited_hits.size() == 0) begin
					report_mismatch("unexpected beat", 1, 0);
				end else begin
					hit_beat_t e;
					e = awaited_hits.pop_front();
					if (res.hit !== e.hit) report_mismatch("hit", res.hit, e.hit);
					if (res.hit_x !== e.px) report_mismatch("hit_x", res.hit_x, e.px);
					if (res.hit_y !== e.py) report_mismatch("hit_y", res.hit_y, e.py);
					if (res.hit_z !== e.pz) report_mismatch("hit_z", res.hit_z, e.pz);
					n_hits += e.hit;
				end
				n_checked++;
			end
		end
	end

	// watchdog on the cycle count
	always @(posedge clk) begin
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("testbench: done, errors");
			$finish;
		end
	end

	task automatic drain();
		wait (pending_rays.size() == 0);
		while (ray.valid || awaited_hits.size() != 0) @(posedge clk);
	endtask

	initial begin
		localparam logic signed [W-1:0] CMAXV = {1'b0, {(W - 1){1'b1}}};
		localparam logic signed [W-1:0] CMINV = {1'b1, {(W - 1){1'b0}}};
		localparam logic signed [W-1:0] ONE = 1 << F;
		localparam int PH_RAYS = 440;
		int idle_set[4] = '{0, 53, 0, 36};
		int stall_set[4] = '{0, 0, 53, 36};
		ray_beat_t r;

		repeat (6) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		// directed: clean hit, origin inside, zero direction on each axis, miss,
		// negative direction, inverted box, saturating extremes, all-ones pattern
		queue_ray('{-ONE*4, 0, 0, ONE, 0, 0, -ONE, -ONE, -ONE, ONE, ONE, ONE});
		queue_ray('{0, 0, 0, ONE, ONE, ONE, -ONE, -ONE, -ONE, ONE, ONE, ONE});
		queue_ray('{0, -ONE*4, 0, 0, ONE, 0, -ONE, -ONE, -ONE, ONE, ONE, ONE});
		queue_ray('{0, 0, -ONE*4, 0, 0, ONE, -ONE, -ONE, -ONE, ONE, ONE, ONE});
		queue_ray('{ONE*4, ONE*4, 0, 0, 0, 0, -ONE, -ONE, -ONE, ONE, ONE, ONE});
		queue_ray('{ONE*4, 0, 0, -ONE, 0, 0, -ONE, -ONE, -ONE, ONE, ONE, ONE});
		queue_ray('{-ONE*4, 0, 0, ONE, 0, 0, ONE, ONE, ONE, -ONE, -ONE, -ONE});
		queue_ray('{-ONE*4, 0, 0, -ONE, 0, 0, -ONE, -ONE, -ONE, ONE, ONE, ONE});
		queue_ray('{CMINV, CMINV, CMINV, CMAXV, CMAXV, CMAXV,
			CMAXV, CMAXV, CMAXV, CMAXV, CMAXV, CMAXV});
		queue_ray('{CMAXV, CMAXV, CMAXV, CMINV, CMINV, CMINV,
			CMINV, CMINV, CMINV, CMINV, CMINV, CMINV});
		queue_ray('{CMINV, 0, 0, 1, 1, 1, -ONE, CMINV, CMINV, CMAXV, CMAXV, CMAXV});
		queue_ray('{CMINV, 0, 0, -1, 1, 1, -ONE, CMINV, CMINV, CMAXV, CMAXV, CMAXV});
		queue_ray('{-1, -1, -1, -1, -1, -1, -1, -1, -1, -1, -1, -1});
		queue_ray('{-ONE*4, ONE/2, ONE/2, ONE, 0, 0, -ONE, 0, 0, ONE, ONE, ONE});
		drain();

		// hold the sender while six aimed rays queue up, then release them
		hold_sender = 1'b1;
		for (int i = 0; i < 6; i++) queue_ray(aimed_ray());
		repeat (LATENCY) @(posedge clk);
		hold_sender = 1'b0;
		drain();

		for (int p = 0; p < 4; p++) begin
			send_idle_pct = idle_set[p];
			recv_stall_pct = stall_set[p];
			for (int i = 0; i < PH_RAYS; i++) begin
				r = ($urandom_range(99) < 75) ? aimed_ray() : noise_ray();
				queue_ray(r);
			end
			drain();
		end
		send_idle_pct = 0;
		recv_stall_pct = 0;
		repeat (LATENCY + 10) @(posedge clk);

		$display("checked %0d result beats, %0d of them hits, over four pacing phases",
			n_checked, n_hits);
		if (n_errors == 0 && awaited_hits.size() == 0) begin
			$display("testbench: done, clean");
		end else begin
			$display("%0d mismatches, %0d results outstanding", n_errors, awaited_hits.size());
			$display("testbench: done, errors");
		end
		$finish;
	end
endmodule

// ===== sim.f =====
hdl/rbs_pkg.sv
hdl/rbs_if.sv
hdl/rbs_recip.sv
hdl/rbs_mul_sat.sv
hdl/ray_box_slab_intersection.sv
tb/rbs_tb_if.sv
tb/testbench.sv
